// ===== rtl/efsf_pkg.sv =====
// ----------------------------------------------------------------------------
// efsf_pkg
// Shared types and constants for the edge update stream filter: verdict
// codes, configuration register indexes and the pipeline slot record.
// ----------------------------------------------------------------------------
package efsf_pkg;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_QUOTA = 4'd1;

  // Verdict codes carried with every result word.
  localparam logic [2:0] VERDICT_KEPT   = 3'd0;
  localparam logic [2:0] VERDICT_RANGE  = 3'd1;
  localparam logic [2:0] VERDICT_DUP    = 3'd2;
  localparam logic [2:0] VERDICT_ABSENT = 3'd3;
  localparam logic [2:0] VERDICT_QUOTA  = 3'd4;

  // Bits per word of the edge map memory.
  localparam int MAP_WORD_W = 32;

  // What the front stage hands to the update stage for one word.
  typedef struct packed {
    logic       valid;
    logic       range_bad;
    logic       mode;
    logic [4:0] bit_sel;
  } slot_t;

endpackage

// ===== rtl/efsf_ram.sv =====
// ----------------------------------------------------------------------------
// efsf_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module efsf_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/efsf_front.sv =====
// ----------------------------------------------------------------------------
// efsf_front
// Front stage: checks the endpoints against the vertex limit, forms the
// map word address and bit position, and issues the map read.
// ----------------------------------------------------------------------------
module efsf_front import efsf_pkg::*; #(
  parameter int MAX_VERTICES = 256,
  parameter int ADDR_W       = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [15:0]       from_vertex,
  input  logic [15:0]       to_vertex,
  input  logic              mode,
  input  logic [8:0]        vertex_limit,
  output logic [ADDR_W-1:0] rd_addr,
  output logic [ADDR_W-1:0] slot_addr,
  output slot_t             slot
);

  localparam int IDX_W = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int POS_W = (2 * IDX_W > 6) ? 2 * IDX_W : 6;

  logic [15:0]      lim;
  logic             range_bad;
  logic [IDX_W-1:0] u_idx;
  logic [IDX_W-1:0] v_idx;
  logic [POS_W-1:0] pos;

  // Effective limit saturates at the map size.
  assign lim = (16'(vertex_limit) > 16'(MAX_VERTICES)) ? 16'(MAX_VERTICES)
                                                        : 16'(vertex_limit);

  // An endpoint of zero or above the limit is out of range.
  assign range_bad = (from_vertex == 16'd0) || (to_vertex == 16'd0) ||
                     (from_vertex > lim) || (to_vertex > lim);

  // Bit position of the pair in the flat map.
  assign u_idx   = IDX_W'(from_vertex - 16'd1);
  assign v_idx   = IDX_W'(to_vertex - 16'd1);
  assign pos     = POS_W'(u_idx) * POS_W'(MAX_VERTICES) + POS_W'(v_idx);
  assign rd_addr = ADDR_W'(pos >> 5);

  // Slot register toward the update stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= take;
    end
    slot.range_bad <= range_bad;
    slot.mode      <= mode;
    slot.bit_sel   <= pos[4:0];
    slot_addr      <= rd_addr;
  end

endmodule

// ===== rtl/efsf_update.sv =====
// ----------------------------------------------------------------------------
// efsf_update
// Update stage: clears the map after reset, judges each word against the
// map bit, the quota and the range check, writes the flipped map word back
// and registers the result word.
// ----------------------------------------------------------------------------
module efsf_update import efsf_pkg::*; #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  slot_t                 slot,
  input  logic [ADDR_W-1:0]     slot_addr,
  input  logic [MAP_WORD_W-1:0] ram_q,
  input  logic [31:0]           update_quota,
  output logic                  we,
  output logic [ADDR_W-1:0]     waddr,
  output logic [MAP_WORD_W-1:0] wdata,
  output logic                  clearing,
  output logic                  done,
  output logic                  accepted,
  output logic [2:0]            verdict,
  output logic [31:0]           kept_count
);

  logic [ADDR_W-1:0]     clr_addr;
  logic                  lw_en;
  logic [ADDR_W-1:0]     lw_addr;
  logic [MAP_WORD_W-1:0] lw_data;
  logic [31:0]           accepted_total;
  logic                  quota_hit;
  logic [31:0]           total_inc;
  logic [MAP_WORD_W-1:0] word;
  logic                  live;
  logic                  keep;
  logic [2:0]            verdict_next;

  // The word written last cycle is not yet visible in the read data.
  assign word = (lw_en && (lw_addr == slot_addr)) ? lw_data : ram_q;
  assign live = word[slot.bit_sel];

  // Check order: quota, range, then the map bit.
  always_comb begin
    keep = 1'b0;
    if (quota_hit) begin
      verdict_next = VERDICT_QUOTA;
    end else if (slot.range_bad) begin
      verdict_next = VERDICT_RANGE;
    end else if (!slot.mode && live) begin
      verdict_next = VERDICT_DUP;
    end else if (slot.mode && !live) begin
      verdict_next = VERDICT_ABSENT;
    end else begin
      verdict_next = VERDICT_KEPT;
      keep         = 1'b1;
    end
  end

  assign total_inc = accepted_total + 32'd1;

  // Map write port: the clearing pass owns it until it finishes.
  always_comb begin
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = slot.valid && keep;
      waddr = slot_addr;
      wdata = word ^ (MAP_WORD_W'(1) << slot.bit_sel);
    end
  end

  // Clearing pass, one word per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Record the last write for forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_en <= 1'b0;
    end else begin
      lw_en <= we;
    end
    lw_addr <= waddr;
    lw_data <= wdata;
  end

  // Count of kept updates and the sticky quota flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_total <= '0;
      quota_hit      <= 1'b0;
    end else if (slot.valid && keep) begin
      accepted_total <= total_inc;
      if (total_inc >= update_quota) begin
        quota_hit <= 1'b1;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= slot.valid;
    end
    accepted   <= keep;
    verdict    <= verdict_next;
    kept_count <= keep ? total_inc : accepted_total;
  end

endmodule

// ===== rtl/edge_update_stream_filter.sv =====
// ----------------------------------------------------------------------------
// edge_update_stream_filter
// Filters a stream of directed edge updates against a memory-resident
// bitmap of live edges, a vertex limit and a quota of kept updates.
//
//   channel   handshake              payload
//   -------   --------------------   -------------------------------------
//   item in   start, busy            from_vertex, to_vertex, mode
//   result    done (one cycle)       accepted, verdict, kept_count
//   config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// One word is taken per cycle while busy is low; its result passes the front
// stage slot register and the update stage result register. The single map
// read-modify-write per word sets this rate, with the word written in the
// previous cycle forwarded past the memory. After reset busy stays high
// while all (MAX_VERTICES*MAX_VERTICES+31)/32 map words are cleared, 2048
// at the default. Results cannot be held off; cfg_ready is always high.
// ----------------------------------------------------------------------------
module edge_update_stream_filter import efsf_pkg::*; #(
  parameter int MAX_VERTICES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [15:0]          from_vertex,
  input  logic [15:0]          to_vertex,
  input  logic                 mode,
  output logic                 done,
  output logic                 accepted,
  output logic [2:0]           verdict,
  output logic [31:0]          kept_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int MAP_BITS = MAX_VERTICES * MAX_VERTICES;
  localparam int DEPTH    = (MAP_BITS + MAP_WORD_W - 1) / MAP_WORD_W;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [8:0]            vertex_limit;
  logic [31:0]           update_quota;
  logic                  take;
  logic                  clearing;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     slot_addr;
  slot_t                 slot;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [MAP_WORD_W-1:0] wdata;
  logic [MAP_WORD_W-1:0] ram_q;

  assign busy      = clearing;
  assign take      = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_limit <= 9'd256;
      update_quota <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VERTEX_LIMIT: vertex_limit <= cfg_data[8:0];
        REG_UPDATE_QUOTA: update_quota <= cfg_data;
        default: ;
      endcase
    end
  end

  // Range check, address and map read.
  efsf_front #(
    .MAX_VERTICES(MAX_VERTICES),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .from_vertex (from_vertex),
    .to_vertex   (to_vertex),
    .mode        (mode),
    .vertex_limit(vertex_limit),
    .rd_addr     (rd_addr),
    .slot_addr   (slot_addr),
    .slot        (slot)
  );

  // Live edge map.
  efsf_ram #(
    .WIDTH (MAP_WORD_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // Judgement, write-back and results.
  efsf_update #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_update (
    .clk         (clk),
    .rst         (rst),
    .slot        (slot),
    .slot_addr   (slot_addr),
    .ram_q       (ram_q),
    .update_quota(update_quota),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .clearing    (clearing),
    .done        (done),
    .accepted    (accepted),
    .verdict     (verdict),
    .kept_count  (kept_count)
  );

endmodule
